// File: sv/rerd_pkg.sv
// shared types and constants for the reprojection error pipeline
package rerd_pkg;

  typedef enum logic [2:0] {
    CFG_ROT_ROW0 = 3'd0,
    CFG_ROT_ROW1 = 3'd1,
    CFG_ROT_ROW2 = 3'd2,
    CFG_TRANS_X  = 3'd3,
    CFG_TRANS_Y  = 3'd4,
    CFG_TRANS_Z  = 3'd5,
    CFG_FOCAL    = 3'd6,
    CFG_RADIAL_K = 3'd7
  } cfg_idx_t;

  localparam logic [47:0] ERR_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] COORD_MAX = 31'h7FFF_FFFF;
  localparam logic [63:0] ROOT_ONE  = 64'h40_0000_0000;
  localparam logic [31:0] SCALE_ONE = 32'h4000_0000;
  localparam logic [32:0] DEN_BASE  = 33'h8_0000;
  localparam logic [50:0] DIV_NUM   = 51'h4_0000_0000_0000;

  typedef struct packed {
    logic        su;
    logic        sv;
    logic        big_u;
    logic        big_v;
    logic        inv;
    logic [31:0] fx;
    logic [31:0] fy;
  } side1_t;

  typedef struct packed {
    logic [30:0] um;
    logic [30:0] vm;
    logic        su;
    logic        sv;
    logic        use_dist;
    logic        inv;
    logic [31:0] fx;
    logic [31:0] fy;
  } side2_t;

endpackage

// File: sv/rerd_udiv.sv
// pipelined restoring unsigned divider, one quotient bit per stage
module rerd_udiv #(
  parameter int NW = 85,
  parameter int DW = 53,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [NW-1:0] rem_in [QW];
  logic [DW-1:0] den_in [QW];
  logic [QW-1:0] q_in   [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int SH = QW - 1 - g;
    logic [NW+QW-1:0] trial;
    logic [NW+QW-1:0] rem_wide;
    logic             ge;
    if (g == 0) begin : g_first
      assign rem_in[g] = num;
      assign den_in[g] = den;
      assign q_in[g]   = '0;
    end else begin : g_next
      assign rem_in[g] = rem_r[g-1];
      assign den_in[g] = den_r[g-1];
      assign q_in[g]   = q_r[g-1];
    end
    assign trial    = {{(NW+QW-DW){1'b0}}, den_in[g]} << SH;
    assign rem_wide = {{QW{1'b0}}, rem_in[g]};
    assign ge       = rem_wide >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? rem_in[g] - trial[NW-1:0] : rem_in[g];
        den_r[g] <= den_in[g];
        q_r[g]   <= ge ? (q_in[g] | (QW'(1) << SH)) : q_in[g];
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// File: sv/rerd_isqrt.sv
// pipelined integer square root, one root bit per stage
module rerd_isqrt #(
  parameter int AW = 64,
  parameter int RW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] rad,
  output logic [RW-1:0] root
);

  logic [AW-1:0] rem_r [RW];
  logic [RW-1:0] res_r [RW];
  logic [AW-1:0] rem_in [RW];
  logic [RW-1:0] res_in [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int B = RW - 1 - g;
    logic [AW+1:0] trial;
    logic          ge;
    if (g == 0) begin : g_first
      assign rem_in[g] = rad;
      assign res_in[g] = '0;
    end else begin : g_next
      assign rem_in[g] = rem_r[g-1];
      assign res_in[g] = res_r[g-1];
    end
    assign trial = ({{(AW+2-RW){1'b0}}, res_in[g]} << (B + 1)) + ((AW+2)'(1) << (2 * B));
    assign ge    = {2'b00, rem_in[g]} >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? rem_in[g] - trial[AW-1:0] : rem_in[g];
        res_r[g] <= ge ? (res_in[g] | (RW'(1) << B)) : res_in[g];
      end
    end
  end

  assign root = res_r[RW-1];

endmodule

// File: sv/reprojection_error_radial_division_top.sv
// top level: pose transform, projection, division distortion and squared error
// throughput: one request per cycle, the whole pipeline holds while the output stalls
// the projection divider, root and scale divider each take one bit per stage
// reset: synchronous active low, clears valid bits and loads identity pose defaults
module reprojection_error_radial_division_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_world_x,
  input  logic [31:0] in_world_y,
  input  logic [31:0] in_world_z,
  input  logic [31:0] in_feature_x,
  input  logic [31:0] in_feature_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_sq_error,
  output logic        out_invalid_pose,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data
);
  import rerd_pkg::*;

  localparam int D1  = 31;
  localparam int D2  = 65;
  localparam int LAT = 110;

  logic        en;
  logic [LAT-1:0] vld_r;

  logic [59:0] rot_r [3];
  logic signed [31:0] tx_r, ty_r, tz_r, k_r;
  logic [31:0] focal_r;

  // config writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 60'd262144;
      rot_r[1] <= 60'd274877906944;
      rot_r[2] <= 60'd288230376151711744;
      tx_r     <= '0;
      ty_r     <= '0;
      tz_r     <= '0;
      focal_r  <= 32'd65536;
      k_r      <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROT_ROW0: rot_r[0] <= cfg_data;
        CFG_ROT_ROW1: rot_r[1] <= cfg_data;
        CFG_ROT_ROW2: rot_r[2] <= cfg_data;
        CFG_TRANS_X:  tx_r     <= cfg_data[31:0];
        CFG_TRANS_Y:  ty_r     <= cfg_data[31:0];
        CFG_TRANS_Z:  tz_r     <= cfg_data[31:0];
        CFG_FOCAL:    focal_r  <= cfg_data[31:0];
        CFG_RADIAL_K: k_r      <= cfg_data[31:0];
        default:      ;
      endcase
    end
  end

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: rotation products
  logic signed [31:0] w_in [3];
  logic signed [51:0] p1_r [3][3];
  logic [31:0] fx1_r, fy1_r;
  assign w_in[0] = in_world_x;
  assign w_in[1] = in_world_y;
  assign w_in[2] = in_world_z;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          p1_r[r][c] <= 52'(signed'(rot_r[r][20*c +: 20])) * 52'(w_in[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx1_r <= in_feature_x;
      fy1_r <= in_feature_y;
    end
  end

  // stage 2: camera point
  logic signed [53:0] pc_r [3];
  logic signed [31:0] t_sel [3];
  logic [31:0] fx2_r, fy2_r;
  assign t_sel[0] = tx_r;
  assign t_sel[1] = ty_r;
  assign t_sel[2] = tz_r;

  for (genvar r = 0; r < 3; r++) begin : g_pc
    always_ff @(posedge clk) begin
      if (en) begin
        pc_r[r] <= 54'(p1_r[r][0]) + 54'(p1_r[r][1]) + 54'(p1_r[r][2])
                 + (54'(t_sel[r]) <<< 18);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx2_r <= fx1_r;
      fy2_r <= fy1_r;
    end
  end

  // stage 3: magnitudes and focal partial products
  logic [52:0] mag_u, mag_v, mag_z;
  logic [58:0] plo_u_r, plo_v_r;
  logic [57:0] phi_u_r, phi_v_r;
  logic [52:0] den3_r;
  logic        su3_r, sv3_r, inv3_r;
  logic [31:0] fx3_r, fy3_r;

  always_comb begin
    mag_u = pc_r[0][53] ? 53'(-pc_r[0]) : 53'(pc_r[0]);
    mag_v = pc_r[1][53] ? 53'(-pc_r[1]) : 53'(pc_r[1]);
    mag_z = pc_r[2][53] ? 53'(-pc_r[2]) : 53'(pc_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_u_r <= 59'(mag_u[26:0]) * 59'(focal_r);
      phi_u_r <= 58'(mag_u[52:27]) * 58'(focal_r);
      plo_v_r <= 59'(mag_v[26:0]) * 59'(focal_r);
      phi_v_r <= 58'(mag_v[52:27]) * 58'(focal_r);
      den3_r  <= mag_z;
      su3_r   <= pc_r[0][53] ^ pc_r[2][53];
      sv3_r   <= pc_r[1][53] ^ pc_r[2][53];
      inv3_r  <= tz_r[31] || (pc_r[2] == '0);
      fx3_r   <= fx2_r;
      fy3_r   <= fy2_r;
    end
  end

  // stage 4: full numerators
  logic [84:0] num4_u_r, num4_v_r;
  logic [52:0] den4_r;
  side1_t      sd4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num4_u_r <= 85'(plo_u_r) + {phi_u_r, 27'd0};
      num4_v_r <= 85'(plo_v_r) + {phi_v_r, 27'd0};
      den4_r   <= den3_r;
      sd4_r    <= '{su: su3_r, sv: sv3_r, big_u: 1'b0, big_v: 1'b0,
                    inv: inv3_r, fx: fx3_r, fy: fy3_r};
    end
  end

  // stage 5: clamp detection
  logic [84:0] num5_u_r, num5_v_r;
  logic [52:0] den5_r;
  side1_t      sd5_r;
  logic [85:0] den_lim;
  logic        big_u, big_v;

  always_comb begin
    den_lim = {2'b00, den4_r, 31'd0};
    big_u   = {1'b0, num4_u_r} >= den_lim;
    big_v   = {1'b0, num4_v_r} >= den_lim;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num5_u_r <= big_u ? '0 : num4_u_r;
      num5_v_r <= big_v ? '0 : num4_v_r;
      den5_r   <= den4_r;
      sd5_r    <= '{su: sd4_r.su, sv: sd4_r.sv, big_u: big_u, big_v: big_v,
                    inv: sd4_r.inv, fx: sd4_r.fx, fy: sd4_r.fy};
    end
  end

  // projection dividers
  logic [30:0] qu, qv;

  rerd_udiv #(.NW(85), .DW(53), .QW(31)) u_div_u (
    .clk(clk), .en(en), .num(num5_u_r), .den(den5_r), .quo(qu)
  );
  rerd_udiv #(.NW(85), .DW(53), .QW(31)) u_div_v (
    .clk(clk), .en(en), .num(num5_v_r), .den(den5_r), .quo(qv)
  );

  side1_t d1_r [D1];
  for (genvar g = 0; g < D1; g++) begin : g_d1
    always_ff @(posedge clk) begin
      if (en) begin
        d1_r[g] <= (g == 0) ? sd5_r : d1_r[(g == 0) ? 0 : g-1];
      end
    end
  end

  // stage 6: clamp and squares
  logic [30:0] um, vm;
  logic [30:0] um6_r, vm6_r;
  logic [61:0] uu6_r, vv6_r;
  side1_t      sd6_r;
  assign um = d1_r[D1-1].big_u ? COORD_MAX : qu;
  assign vm = d1_r[D1-1].big_v ? COORD_MAX : qv;

  always_ff @(posedge clk) begin
    if (en) begin
      um6_r <= um;
      vm6_r <= vm;
      uu6_r <= 62'(um) * 62'(um);
      vv6_r <= 62'(vm) * 62'(vm);
      sd6_r <= d1_r[D1-1];
    end
  end

  // stage 7: r squared
  logic [62:0] rr7_r;
  logic [30:0] um7_r, vm7_r;
  side1_t      sd7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rr7_r <= 63'(uu6_r) + 63'(vv6_r);
      um7_r <= um6_r;
      vm7_r <= vm6_r;
      sd7_r <= sd6_r;
    end
  end

  // stage 8: k times r squared partial products
  logic [31:0] kmag;
  logic [63:0] pl8_r;
  logic [62:0] ph8_r;
  logic [30:0] um8_r, vm8_r;
  side1_t      sd8_r;
  assign kmag = k_r[31] ? 32'(-k_r) : 32'(k_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pl8_r <= 64'(rr7_r[31:0]) * 64'(kmag);
      ph8_r <= 63'(rr7_r[62:32]) * 63'(kmag);
      um8_r <= um7_r;
      vm8_r <= vm7_r;
      sd8_r <= sd7_r;
    end
  end

  // stage 9: m
  logic [63:0] m9_r;
  logic [30:0] um9_r, vm9_r;
  side1_t      sd9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m9_r  <= 64'(ph8_r) + 64'(pl8_r[63:32]);
      um9_r <= um8_r;
      vm9_r <= vm8_r;
      sd9_r <= sd8_r;
    end
  end

  // stage 10: root argument
  logic        kpos, use_d;
  logic [63:0] a10_r;
  side2_t      sd10_r;
  assign kpos  = !k_r[31] && (k_r != '0);
  assign use_d = (k_r != '0) && (m9_r != '0) && !(kpos && (m9_r > ROOT_ONE));

  always_ff @(posedge clk) begin
    if (en) begin
      if (!use_d) begin
        a10_r <= '0;
      end else if (kpos) begin
        a10_r <= ROOT_ONE - m9_r;
      end else begin
        a10_r <= ROOT_ONE + m9_r;
      end
      sd10_r <= '{um: um9_r, vm: vm9_r, su: sd9_r.su, sv: sd9_r.sv, use_dist: use_d,
                  inv: sd9_r.inv, fx: sd9_r.fx, fy: sd9_r.fy};
    end
  end

  logic [31:0] root;
  rerd_isqrt #(.AW(64), .RW(32)) u_sqrt (
    .clk(clk), .en(en), .rad(a10_r), .root(root)
  );

  // stage 11: scale denominator
  logic [32:0] den11_r;
  always_ff @(posedge clk) begin
    if (en) begin
      den11_r <= DEN_BASE + 33'(root);
    end
  end

  logic [31:0] sq;
  rerd_udiv #(.NW(51), .DW(33), .QW(32)) u_div_s (
    .clk(clk), .en(en), .num(DIV_NUM), .den(den11_r), .quo(sq)
  );

  side2_t d2_r [D2];
  for (genvar g = 0; g < D2; g++) begin : g_d2
    always_ff @(posedge clk) begin
      if (en) begin
        d2_r[g] <= (g == 0) ? sd10_r : d2_r[(g == 0) ? 0 : g-1];
      end
    end
  end

  // stage 12: distorted magnitudes
  logic [31:0] s12;
  logic [62:0] pu, pv;
  logic [32:0] ru12_r, rv12_r;
  side2_t      sd12_r;
  assign s12 = d2_r[D2-1].use_dist ? sq : SCALE_ONE;
  assign pu  = 63'(d2_r[D2-1].um) * 63'(s12);
  assign pv  = 63'(d2_r[D2-1].vm) * 63'(s12);

  always_ff @(posedge clk) begin
    if (en) begin
      ru12_r <= pu[62:30];
      rv12_r <= pv[62:30];
      sd12_r <= d2_r[D2-1];
    end
  end

  // stage 13: differences
  logic signed [34:0] su13, sv13;
  logic signed [34:0] dx13_r, dy13_r;
  logic        inv13_r;
  assign su13 = sd12_r.su ? -signed'({2'b00, ru12_r}) : signed'({2'b00, ru12_r});
  assign sv13 = sd12_r.sv ? -signed'({2'b00, rv12_r}) : signed'({2'b00, rv12_r});

  always_ff @(posedge clk) begin
    if (en) begin
      dx13_r  <= su13 - 35'(signed'(sd12_r.fx));
      dy13_r  <= sv13 - 35'(signed'(sd12_r.fy));
      inv13_r <= sd12_r.inv;
    end
  end

  // stage 14: squared differences
  logic [34:0] mdx, mdy;
  logic [63:0] sx14_r, sy14_r;
  logic        sat14_r, inv14_r;
  assign mdx = dx13_r[34] ? 35'(-dx13_r) : 35'(dx13_r);
  assign mdy = dy13_r[34] ? 35'(-dy13_r) : 35'(dy13_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sx14_r  <= 64'(mdx[31:0]) * 64'(mdx[31:0]);
      sy14_r  <= 64'(mdy[31:0]) * 64'(mdy[31:0]);
      sat14_r <= (mdx[34:32] != '0) || (mdy[34:32] != '0);
      inv14_r <= inv13_r;
    end
  end

  // stage 15: rounding, saturation and output register
  logic [64:0] sum;
  logic [48:0] res;
  logic [47:0] err_r;
  logic        inv_r;
  assign sum = 65'(sx14_r) + 65'(sy14_r);
  assign res = {1'b0, sum[63:16]} + 49'(sum[15]);

  always_ff @(posedge clk) begin
    if (en) begin
      inv_r <= inv14_r;
      if (inv14_r || sat14_r || sum[64] || res[48]) begin
        err_r <= ERR_MAX;
      end else begin
        err_r <= res[47:0];
      end
    end
  end

  assign out_valid        = vld_r[LAT-1];
  assign out_sq_error     = err_r;
  assign out_invalid_pose = inv_r;

  // checks
  a_inv_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_pose |-> out_sq_error == ERR_MAX)
    else $error("invalid pose without saturated error");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> vld_r == $past(vld_r))
    else $error("pipeline moved during output stall");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid bits not cleared by reset");

endmodule

// File: dv/reprojection_error_radial_division_top_tb.sv
// testbench for the reprojection error pipeline with division distortion
module reprojection_error_radial_division_top_tb;
  import rerd_pkg::*;

  typedef struct packed {
    logic [47:0] err;
    logic        inv;
  } reproj_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_world_x;
  logic [31:0] in_world_y;
  logic [31:0] in_world_z;
  logic [31:0] in_feature_x;
  logic [31:0] in_feature_y;
  logic        out_valid;
  logic        out_ready;
  logic [47:0] out_sq_error;
  logic        out_invalid_pose;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [59:0] cfg_data;

  logic [59:0]    pose_reg [8];
  reproj_result_t pending_errors [$];
  int unsigned    fail_count;
  int unsigned    cycle_count;
  int unsigned    hold_cycles;
  bit             send_idle_en;
  bit             recv_idle_en;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 130;

  reprojection_error_radial_division_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_world_x(in_world_x), .in_world_y(in_world_y), .in_world_z(in_world_z),
    .in_feature_x(in_feature_x), .in_feature_y(in_feature_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sq_error(out_sq_error), .out_invalid_pose(out_invalid_pose),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] mag(input longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint project_axis(input longint p, input longint z,
                                          input logic [31:0] f);
    logic [127:0] quot;
    quot = (128'(mag(p)) * 128'(f)) / 128'(mag(z));
    if (quot > 128'(COORD_MAX)) quot = 128'(COORD_MAX);
    return ((p < 0) != (z < 0)) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
  endfunction

  function automatic longint distort(input longint u, input logic [63:0] s);
    logic [127:0] r;
    r = (128'(mag(u)) * 128'(s)) >> 30;
    return u < 0 ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic reproj_result_t predict_error(input logic [31:0] wx, wy, wz, fx, fy);
    logic [31:0]        w [3];
    longint             pc [3];
    longint             acc, u, v, kv, dx, dy;
    logic signed [19:0] re;
    logic [127:0]       prod;
    logic [63:0]        rr, m, s, a;
    logic [64:0]        sum;
    logic [48:0]        res;
    w[0] = wx; w[1] = wy; w[2] = wz;
    for (int r = 0; r < 3; r++) begin
      acc = longint'($signed(pose_reg[3 + r][31:0])) * 262144;
      for (int c = 0; c < 3; c++) begin
        re = pose_reg[r][20 * c +: 20];
        acc += longint'(re) * longint'($signed(w[c]));
      end
      pc[r] = acc;
    end
    if ($signed(pose_reg[CFG_TRANS_Z][31:0]) < 0 || pc[2] == 0) return '{ERR_MAX, 1'b1};
    u = project_axis(pc[0], pc[2], pose_reg[CFG_FOCAL][31:0]);
    v = project_axis(pc[1], pc[2], pose_reg[CFG_FOCAL][31:0]);
    rr = mag(u) * mag(u) + mag(v) * mag(v);
    kv = longint'($signed(pose_reg[CFG_RADIAL_K][31:0]));
    prod = 128'(rr) * 128'(mag(kv));
    m = prod[95:32];
    s = 64'd1 << 30;
    if (kv != 0 && m != 0 && !(kv > 0 && m > (64'd1 << 38))) begin
      a = kv > 0 ? (64'd1 << 38) - m : (64'd1 << 38) + m;
      s = (64'd1 << 50) / ((64'd1 << 19) + isqrt(a));
    end
    dx = distort(u, s) - longint'($signed(fx));
    dy = distort(v, s) - longint'($signed(fy));
    if (mag(dx) >= (64'd1 << 32) || mag(dy) >= (64'd1 << 32)) return '{ERR_MAX, 1'b0};
    sum = 65'(mag(dx) * mag(dx)) + 65'(mag(dy) * mag(dy));
    if (sum[64]) return '{ERR_MAX, 1'b0};
    res = 49'(sum[63:16]) + 49'(sum[15]);
    return '{res > 49'(ERR_MAX) ? ERR_MAX : res[47:0], 1'b0};
  endfunction

  task automatic send_point(input logic [31:0] wx, wy, wz, fx, fy);
    int unsigned gap;
    gap = send_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_world_x <= wx; in_world_y <= wy; in_world_z <= wz;
    in_feature_x <= fx; in_feature_y <= fy;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_errors.push_back(predict_error(wx, wy, wz, fx, fy));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_errors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [59:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    pose_reg[idx] = (idx <= CFG_ROT_ROW2) ? val : {28'd0, val[31:0]};
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_identity;
    write_reg(CFG_ROT_ROW0, 60'h0_0000_0000_4_0000);
    write_reg(CFG_ROT_ROW1, 60'h0_0000_4000_0_0000);
    write_reg(CFG_ROT_ROW2, 60'h0_4000_0000_0_0000);
    write_reg(CFG_TRANS_X, 60'd0);
    write_reg(CFG_TRANS_Y, 60'd0);
    write_reg(CFG_TRANS_Z, 60'd0);
    write_reg(CFG_FOCAL, 60'h1_0000);
    write_reg(CFG_RADIAL_K, 60'd0);
  endtask

  task automatic test_reset_pose;
    send_point(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_point(32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
    send_point(32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 32'd5, 32'hFFFF_FFFB);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_invalid_depth;
    write_reg(CFG_TRANS_Z, 60'h8000_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'd0, 32'd0);
    drain();
    write_reg(CFG_TRANS_Z, 60'hFFFF_FFFF);
    send_point(32'd0, 32'd0, 32'h0004_0000, 32'd0, 32'd0);
    drain();
    write_reg(CFG_TRANS_Z, 60'h7FFF_FFFF);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'd0, 32'd0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0001, 32'd7, 32'd3);
    drain();
  endtask

  task automatic test_focal_extremes;
    write_reg(CFG_TRANS_Z, 60'h0005_0000);
    write_reg(CFG_FOCAL, 60'd0);
    send_point(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000);
    drain();
    write_reg(CFG_FOCAL, 60'hFFFF_FFFF);
    send_point(32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'd1, 32'd1, 32'h7FFF_0000, 32'd0, 32'd0);
    drain();
  endtask

  task automatic test_distortion;
    write_reg(CFG_FOCAL, 60'h0100_0000);
    write_reg(CFG_RADIAL_K, 60'd1);
    send_point(32'd1, 32'd0, 32'h0010_0000, 32'd0, 32'd0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'd0);
    drain();
    write_reg(CFG_RADIAL_K, 60'h7FFF_FFFF);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'd0, 32'd0);
    send_point(32'h0000_0100, 32'h0000_0080, 32'h0001_0000, 32'd0, 32'd0);
    drain();
    write_reg(CFG_RADIAL_K, 60'h8000_0000);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'd0, 32'd0);
    send_point(32'h0000_0100, 32'hFFFF_FF00, 32'h0001_0000, 32'd3, 32'd4);
    drain();
    write_reg(CFG_ROT_ROW0, 60'hFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_ROT_ROW1, 60'h800_0080_0008_0000);
    write_reg(CFG_ROT_ROW2, 60'h7FF_FF7F_FFF7_FFFF);
    write_reg(CFG_TRANS_X, 60'h8000_0000);
    write_reg(CFG_TRANS_Y, 60'h7FFF_FFFF);
    write_reg(CFG_RADIAL_K, 60'hFFFF_FF00);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'd0, 32'd0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd9, 32'd1);
    drain();
    load_identity();
  endtask

  function automatic logic [31:0] scene_coord(input int unsigned span);
    return 32'($signed($urandom_range(0, 2 * span)) - $signed(span));
  endfunction

  task automatic randomize_pose;
    for (int r = 0; r < 3; r++) begin
      if ($urandom_range(0, 3) == 0)
        write_reg(cfg_idx_t'(r), 60'({$urandom, $urandom}));
      else
        write_reg(cfg_idx_t'(r), 60'({20'(scene_coord(300000)), 20'(scene_coord(300000)),
                                     20'(scene_coord(300000))}));
    end
    write_reg(CFG_TRANS_X, 60'(scene_coord(1 << 20)));
    write_reg(CFG_TRANS_Y, 60'(scene_coord(1 << 20)));
    if ($urandom_range(0, 7) == 0) write_reg(CFG_TRANS_Z, 60'($urandom));
    else write_reg(CFG_TRANS_Z, 60'($urandom_range(1 << 18, 1 << 22)));
    case ($urandom_range(0, 3))
      0: write_reg(CFG_FOCAL, 60'($urandom));
      1: write_reg(CFG_FOCAL, 60'($urandom_range(0, 1 << 16)));
      default: write_reg(CFG_FOCAL, 60'($urandom_range(1 << 16, 1 << 26)));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(CFG_RADIAL_K, 60'($urandom));
      1: write_reg(CFG_RADIAL_K, 60'd0);
      default: write_reg(CFG_RADIAL_K, 60'(scene_coord(1 << $urandom_range(0, 20))));
    endcase
  endtask

  task automatic send_random_point;
    if ($urandom_range(0, 4) == 0)
      send_point($urandom, $urandom, $urandom, $urandom, $urandom);
    else
      send_point(scene_coord(10 << 16), scene_coord(10 << 16), scene_coord(10 << 16),
                 scene_coord(1 << $urandom_range(4, 31)), scene_coord(1 << $urandom_range(4, 31)));
  endtask

  task automatic test_random_poses;
    for (int phase = 0; phase < 12; phase++) begin
      randomize_pose();
      send_idle_en = phase % 4 != 1;
      recv_idle_en = phase % 4 != 2;
      repeat (85) send_random_point();
      drain();
    end
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  task automatic test_output_stall;
    send_idle_en = 1'b0;
    hold_cycles = 400;
    repeat (200) send_random_point();
    drain();
    send_idle_en = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_world_x = '0; in_world_y = '0; in_world_z = '0;
    in_feature_x = '0; in_feature_y = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    hold_cycles = 0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    pose_reg[CFG_ROT_ROW0] = 60'd262144;
    pose_reg[CFG_ROT_ROW1] = 60'd274877906944;
    pose_reg[CFG_ROT_ROW2] = 60'd288230376151711744;
    pose_reg[CFG_TRANS_X] = 60'd0;
    pose_reg[CFG_TRANS_Y] = 60'd0;
    pose_reg[CFG_TRANS_Z] = 60'd0;
    pose_reg[CFG_FOCAL] = 60'd65536;
    pose_reg[CFG_RADIAL_K] = 60'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_pose();
    test_invalid_depth();
    test_focal_extremes();
    test_distortion();
    test_random_poses();
    test_output_stall();
    if (fail_count == 0) $display("[reprojection_error_radial_division_top] OK");
    else $display("[reprojection_error_radial_division_top] ERROR");
    $finish;
  end

  // result side, with per-request stall and an occasional long hold-off
  initial begin
    int unsigned n;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = recv_idle_en ? $urandom_range(0, 12) : 0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    reproj_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_errors.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result: actual err=%h inv=%b", $time, out_sq_error,
                 out_invalid_pose);
      end else begin
        exp_res = pending_errors.pop_front();
        if (out_sq_error !== exp_res.err) begin
          fail_count++;
          $display("%0t sq_error mismatch: expected %h actual %h", $time, exp_res.err,
                   out_sq_error);
        end
        if (out_invalid_pose !== exp_res.inv) begin
          fail_count++;
          $display("%0t invalid_pose mismatch: expected %b actual %b", $time, exp_res.inv,
                   out_invalid_pose);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[reprojection_error_radial_division_top] ERROR");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

// File: reprojection_error_radial_division_top.f
sv/rerd_pkg.sv
sv/rerd_udiv.sv
sv/rerd_isqrt.sv
sv/reprojection_error_radial_division_top.sv
dv/reprojection_error_radial_division_top_tb.sv
